@@ rtl/core/rwlt_pkg.sv @@
// ----------------------------------------------------------------------------
// rwlt_pkg
// Shared constants, codes and the result type of the reader-writer lock table.
// ----------------------------------------------------------------------------
package rwlt_pkg;

  // Default sizes for the top level parameters
  localparam int FILE_ENTRIES_DEF = 64;
  localparam int PAIR_ENTRIES_DEF = 128;
  localparam int ID_BITS_DEF      = 16;
  localparam int COUNT_BITS_DEF   = 16;

  // Fixed field widths
  localparam int OP_W  = 2;
  localparam int ST_W  = 3;
  localparam int REL_W = 22;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_ACQ_RD  = 2'd0;
  localparam logic [OP_W-1:0] OP_ACQ_WR  = 2'd1;
  localparam logic [OP_W-1:0] OP_REL_ONE = 2'd2;
  localparam logic [OP_W-1:0] OP_REL_ALL = 2'd3;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_CONFLICT = 3'd1;
  localparam logic [ST_W-1:0] ST_INVALID  = 3'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_NOROOM   = 3'd4;
  localparam logic [ST_W-1:0] ST_INCONS   = 3'd5;

  // One result item
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [REL_W-1:0] released_count;
  } rwlt_result_t;

endpackage

@@ rtl/core/rwlt_result_reg.sv @@
// ----------------------------------------------------------------------------
// rwlt_result_reg
// Output register: holds one finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module rwlt_result_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  rwlt_pkg::rwlt_result_t push_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rwlt_pkg::rwlt_result_t out_data
);
  import rwlt_pkg::*;

  logic         full_r;
  rwlt_result_t data_r;

  // Accept a new result when empty or when the held one leaves this cycle
  assign push_ready = !full_r || out_ready;
  assign out_valid  = full_r;
  assign out_data   = data_r;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (push_valid && push_ready) begin
      full_r <= 1'b1;
    end else if (out_ready) begin
      full_r <= 1'b0;
    end
  end

  // Hold the payload
  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      data_r <= push_data;
    end
  end

endmodule

@@ rtl/core/reader_writer_lock_table.sv @@
// ----------------------------------------------------------------------------
// reader_writer_lock_table
// Reader-writer lock manager over a file table and a holder-file pair table.
// ----------------------------------------------------------------------------
// Usage: a request (opcode, file id, holder id) is a transfer on the in_
// channel; exactly one result (status, released count) follows on the out_
// channel, in request order. One request is worked on at a time.
// Both tables live in synchronous memories with one write port and a registered
// read port, and are searched one entry per cycle. An acquire scans the file
// table and then the pair table; a release one does the same, but stops after
// the file scan if the file is not found. A match ends a scan early.
// A release all walks the pair table; for each pair of the holder it scans the
// file table and then updates both entries. Invalid ids skip all scans.
// After reset the block sweeps both memories to clear them, and keeps
// in_ready low meanwhile.
// A finished result sits in an output register; the next request is taken
// while it waits, and a stalled receiver only holds the block once a second
// result is ready.
module reader_writer_lock_table #(
  parameter int FILE_ENTRIES = rwlt_pkg::FILE_ENTRIES_DEF,
  parameter int PAIR_ENTRIES = rwlt_pkg::PAIR_ENTRIES_DEF,
  parameter int ID_BITS      = rwlt_pkg::ID_BITS_DEF,
  parameter int COUNT_BITS   = rwlt_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rwlt_pkg::OP_W-1:0]  in_opcode,
  input  logic [ID_BITS-1:0]         in_file_id,
  input  logic [ID_BITS-1:0]         in_holder_id,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rwlt_pkg::ST_W-1:0]  out_status,
  output logic [rwlt_pkg::REL_W-1:0] out_released_count
);
  import rwlt_pkg::*;

  localparam int FA   = $clog2(FILE_ENTRIES);
  localparam int PA   = $clog2(PAIR_ENTRIES);
  localparam int MAXD = (FILE_ENTRIES > PAIR_ENTRIES) ? FILE_ENTRIES : PAIR_ENTRIES;
  localparam int IW   = $clog2(MAXD) + 1;
  localparam int FW   = 1 + ID_BITS + COUNT_BITS;
  localparam int PW   = 1 + 2 * ID_BITS + COUNT_BITS;
  localparam logic [IW-1:0] F_END   = IW'(FILE_ENTRIES);
  localparam logic [IW-1:0] P_END   = IW'(PAIR_ENTRIES);
  localparam logic [IW-1:0] CLR_END = IW'(MAXD - 1);
  localparam logic [PA:0]   W_END   = (PA + 1)'(PAIR_ENTRIES);
  localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
  localparam logic signed [COUNT_BITS-1:0] CNT_NEG = '1;

  // Sequencer states
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FSCAN = 4'd2;
  localparam logic [3:0] S_PSCAN = 4'd3;
  localparam logic [3:0] S_EXEC  = 4'd4;
  localparam logic [3:0] S_WRD   = 4'd5;
  localparam logic [3:0] S_WCHK  = 4'd6;
  localparam logic [3:0] S_WUPD  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  // Memories: file {valid, id, count}, pair {valid, holder, file, count}
  logic [FW-1:0] file_mem [FILE_ENTRIES];
  logic [PW-1:0] pair_mem [PAIR_ENTRIES];
  logic [FW-1:0] file_q_r;
  logic [PW-1:0] pair_q_r;
  logic          file_we, pair_we;
  logic [FA-1:0] file_wa, file_ra;
  logic [PA-1:0] pair_wa, pair_ra;
  logic [FW-1:0] file_wd;
  logic [PW-1:0] pair_wd;

  // Control and working registers
  logic [3:0]                    state_r, state_nxt;
  logic [IW-1:0]                 clr_r, clr_nxt;
  logic [OP_W-1:0]               op_r, op_nxt;
  logic [ID_BITS-1:0]            file_r, file_nxt;
  logic [ID_BITS-1:0]            hold_r, hold_nxt;
  logic [IW-1:0]                 rd_idx_r, rd_idx_nxt;
  logic                          chk_v_r, chk_v_nxt;
  logic [IW-1:0]                 chk_idx_r, chk_idx_nxt;
  logic                          f_hit_r, f_hit_nxt;
  logic [FA-1:0]                 f_idx_r, f_idx_nxt;
  logic signed [COUNT_BITS-1:0]  f_cnt_r, f_cnt_nxt;
  logic                          f_free_ok_r, f_free_ok_nxt;
  logic [FA-1:0]                 f_free_r, f_free_nxt;
  logic                          p_hit_r, p_hit_nxt;
  logic [PA-1:0]                 p_idx_r, p_idx_nxt;
  logic signed [COUNT_BITS-1:0]  p_cnt_r, p_cnt_nxt;
  logic                          p_free_ok_r, p_free_ok_nxt;
  logic [PA-1:0]                 p_free_r, p_free_nxt;
  logic [PA:0]                   w_idx_r, w_idx_nxt;
  logic signed [COUNT_BITS-1:0]  w_pc_r, w_pc_nxt;
  logic [REL_W-1:0]              rel_r, rel_nxt;
  logic [ST_W-1:0]               st_r, st_nxt;

  // Read data fields
  logic                         fq_valid, pq_valid;
  logic [ID_BITS-1:0]           fq_id, pq_holder, pq_file;
  logic signed [COUNT_BITS-1:0] fq_cnt, pq_cnt;
  logic                         f_match, p_match, f_end, p_end;
  logic signed [COUNT_BITS-1:0] walk_fc;
  logic [REL_W+COUNT_BITS-1:0]  pc_ext;
  logic                         is_wr;
  logic [COUNT_BITS-1:0]        new_cnt;

  // Result handoff
  logic         rb_push, rb_ready;
  rwlt_result_t rb_data, rb_out;

  assign fq_valid  = file_q_r[FW-1];
  assign fq_id     = file_q_r[COUNT_BITS+ID_BITS-1:COUNT_BITS];
  assign fq_cnt    = file_q_r[COUNT_BITS-1:0];
  assign pq_valid  = pair_q_r[PW-1];
  assign pq_holder = pair_q_r[COUNT_BITS+2*ID_BITS-1:COUNT_BITS+ID_BITS];
  assign pq_file   = pair_q_r[COUNT_BITS+ID_BITS-1:COUNT_BITS];
  assign pq_cnt    = pair_q_r[COUNT_BITS-1:0];

  assign f_match = chk_v_r && fq_valid && (fq_id == file_r);
  assign p_match = chk_v_r && pq_valid && (pq_holder == hold_r) && (pq_file == file_r)
                   && f_hit_r;
  assign f_end   = f_match || (!chk_v_r && (rd_idx_r >= F_END));
  assign p_end   = p_match || (!chk_v_r && (rd_idx_r >= P_END));
  assign walk_fc = f_cnt_r - w_pc_r;
  assign pc_ext  = {{REL_W{1'b0}}, w_pc_r};
  assign is_wr   = (op_r == OP_ACQ_WR);
  assign new_cnt = is_wr ? CNT_NEG : CNT_ONE;

  assign in_ready = (state_r == S_IDLE);
  assign rb_data.status         = st_r;
  assign rb_data.released_count = rel_r;

  // Sequencer: scans, read-modify-write and the release-all walk
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    file_nxt      = file_r;
    hold_nxt      = hold_r;
    rd_idx_nxt    = rd_idx_r;
    chk_v_nxt     = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    f_hit_nxt     = f_hit_r;
    f_idx_nxt     = f_idx_r;
    f_cnt_nxt     = f_cnt_r;
    f_free_ok_nxt = f_free_ok_r;
    f_free_nxt    = f_free_r;
    p_hit_nxt     = p_hit_r;
    p_idx_nxt     = p_idx_r;
    p_cnt_nxt     = p_cnt_r;
    p_free_ok_nxt = p_free_ok_r;
    p_free_nxt    = p_free_r;
    w_idx_nxt     = w_idx_r;
    w_pc_nxt      = w_pc_r;
    rel_nxt       = rel_r;
    st_nxt        = st_r;
    file_we       = 1'b0;
    file_wa       = f_idx_r;
    file_wd       = '0;
    pair_we       = 1'b0;
    pair_wa       = p_idx_r;
    pair_wd       = '0;
    file_ra       = rd_idx_r[FA-1:0];
    pair_ra       = rd_idx_r[PA-1:0];
    rb_push       = 1'b0;

    case (state_r)
      S_CLR: begin
        // Sweep both memories to invalid entries
        file_we = (clr_r < F_END);
        file_wa = clr_r[FA-1:0];
        pair_we = (clr_r < P_END);
        pair_wa = clr_r[PA-1:0];
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CLR_END) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        // Latch the request and pick the first step
        if (in_valid) begin
          op_nxt        = in_opcode;
          file_nxt      = in_file_id;
          hold_nxt      = in_holder_id;
          f_hit_nxt     = 1'b0;
          p_hit_nxt     = 1'b0;
          f_free_ok_nxt = 1'b0;
          p_free_ok_nxt = 1'b0;
          rd_idx_nxt    = '0;
          w_idx_nxt     = '0;
          rel_nxt       = '0;
          if (in_opcode == OP_REL_ALL) begin
            if (in_holder_id == '0) begin
              st_nxt    = ST_INVALID;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_WRD;
            end
          end else if ((in_file_id == '0) || (in_holder_id == '0)) begin
            st_nxt    = ST_INVALID;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_FSCAN;
          end
        end
      end

      S_FSCAN: begin
        // Issue one read a cycle, compare the entry read the cycle before
        if (rd_idx_r < F_END) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
          chk_v_nxt  = 1'b1;
        end
        chk_idx_nxt = rd_idx_r;
        if (chk_v_r && !fq_valid && !f_free_ok_r) begin
          f_free_ok_nxt = 1'b1;
          f_free_nxt    = chk_idx_r[FA-1:0];
        end
        if (f_match) begin
          f_hit_nxt = 1'b1;
          f_idx_nxt = chk_idx_r[FA-1:0];
          f_cnt_nxt = fq_cnt;
        end
        if (f_end) begin
          chk_v_nxt  = 1'b0;
          rd_idx_nxt = '0;
          if (op_r == OP_REL_ALL) begin
            state_nxt = S_WUPD;
          end else if ((op_r == OP_REL_ONE) && !f_match) begin
            st_nxt    = ST_NOTFOUND;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_PSCAN;
          end
        end
      end

      S_PSCAN: begin
        // Search the pair, noting the lowest free slot on the way
        if (rd_idx_r < P_END) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
          chk_v_nxt  = 1'b1;
        end
        chk_idx_nxt = rd_idx_r;
        if (chk_v_r && !pq_valid && !p_free_ok_r) begin
          p_free_ok_nxt = 1'b1;
          p_free_nxt    = chk_idx_r[PA-1:0];
        end
        if (p_match) begin
          p_hit_nxt = 1'b1;
          p_idx_nxt = chk_idx_r[PA-1:0];
          p_cnt_nxt = pq_cnt;
        end
        if (p_end) begin
          chk_v_nxt = 1'b0;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        // Decide and write back
        state_nxt = S_DONE;
        if (op_r == OP_REL_ONE) begin
          if (!p_hit_r) begin
            st_nxt = ST_NOTFOUND;
          end else if ((f_cnt_r[COUNT_BITS-1] != p_cnt_r[COUNT_BITS-1]) ||
                       ((p_cnt_r > 0) && (f_cnt_r < p_cnt_r))) begin
            st_nxt = ST_INCONS;
          end else begin
            st_nxt  = ST_OK;
            file_we = 1'b1;
            file_wa = f_idx_r;
            file_wd = {(f_cnt_r > CNT_ONE), file_r, f_cnt_r - CNT_ONE};
            pair_we = 1'b1;
            pair_wa = p_idx_r;
            pair_wd = {(p_cnt_r > CNT_ONE), hold_r, file_r, p_cnt_r - CNT_ONE};
          end
        end else if (!f_hit_r) begin
          if (!f_free_ok_r || !p_free_ok_r) begin
            st_nxt = ST_NOROOM;
          end else begin
            st_nxt  = ST_OK;
            file_we = 1'b1;
            file_wa = f_free_r;
            file_wd = {1'b1, file_r, new_cnt};
            pair_we = 1'b1;
            pair_wa = p_free_r;
            pair_wd = {1'b1, hold_r, file_r, new_cnt};
          end
        end else if (f_cnt_r[COUNT_BITS-1] || is_wr) begin
          st_nxt = ST_CONFLICT;
        end else if (f_cnt_r >= CNT_MAX) begin
          st_nxt = ST_NOROOM;
        end else if (p_hit_r) begin
          if (p_cnt_r[COUNT_BITS-1]) begin
            st_nxt = ST_INCONS;
          end else if (p_cnt_r >= CNT_MAX) begin
            st_nxt = ST_NOROOM;
          end else begin
            st_nxt  = ST_OK;
            file_we = 1'b1;
            file_wa = f_idx_r;
            file_wd = {1'b1, file_r, f_cnt_r + CNT_ONE};
            pair_we = 1'b1;
            pair_wa = p_idx_r;
            pair_wd = {1'b1, hold_r, file_r, p_cnt_r + CNT_ONE};
          end
        end else if (!p_free_ok_r) begin
          st_nxt = ST_NOROOM;
        end else begin
          st_nxt  = ST_OK;
          file_we = 1'b1;
          file_wa = f_idx_r;
          file_wd = {1'b1, file_r, f_cnt_r + CNT_ONE};
          pair_we = 1'b1;
          pair_wa = p_free_r;
          pair_wd = {1'b1, hold_r, file_r, CNT_ONE};
        end
      end

      S_WRD: begin
        // Read the next pair of the walk, or finish
        pair_ra = w_idx_r[PA-1:0];
        if (w_idx_r >= W_END) begin
          st_nxt    = ST_OK;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_WCHK;
        end
      end

      S_WCHK: begin
        // A pair of this holder starts a scan for its file
        if (pq_valid && (pq_holder == hold_r)) begin
          file_nxt      = pq_file;
          w_pc_nxt      = pq_cnt;
          f_hit_nxt     = 1'b0;
          f_free_ok_nxt = 1'b0;
          rd_idx_nxt    = '0;
          state_nxt     = S_FSCAN;
        end else begin
          w_idx_nxt = w_idx_r + 1'b1;
          state_nxt = S_WRD;
        end
      end

      S_WUPD: begin
        // Free the pair's locks from its file, or stop on a mismatch
        pair_wa = w_idx_r[PA-1:0];
        file_wa = f_idx_r;
        if (!f_hit_r) begin
          st_nxt    = ST_INCONS;
          state_nxt = S_DONE;
        end else if ((w_pc_r > 0) && (f_cnt_r >= w_pc_r)) begin
          file_we   = 1'b1;
          file_wd   = {(walk_fc != '0), file_r, walk_fc};
          pair_we   = 1'b1;
          rel_nxt   = rel_r + pc_ext[REL_W-1:0];
          w_idx_nxt = w_idx_r + 1'b1;
          state_nxt = S_WRD;
        end else if (w_pc_r[COUNT_BITS-1] && f_cnt_r[COUNT_BITS-1]) begin
          file_we   = 1'b1;
          file_wd   = {1'b0, file_r, f_cnt_r};
          pair_we   = 1'b1;
          rel_nxt   = rel_r + 1'b1;
          w_idx_nxt = w_idx_r + 1'b1;
          state_nxt = S_WRD;
        end else begin
          st_nxt    = ST_INCONS;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // Hand the result to the output register
        rb_push = 1'b1;
        if (rb_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Memories
  always_ff @(posedge clk) begin
    if (file_we) begin
      file_mem[file_wa] <= file_wd;
    end
    file_q_r <= file_mem[file_ra];
  end

  always_ff @(posedge clk) begin
    if (pair_we) begin
      pair_mem[pair_wa] <= pair_wd;
    end
    pair_q_r <= pair_mem[pair_ra];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      chk_v_r <= 1'b0;
      f_hit_r <= 1'b0;
      p_hit_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      chk_v_r <= chk_v_nxt;
      f_hit_r <= f_hit_nxt;
      p_hit_r <= p_hit_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    file_r      <= file_nxt;
    hold_r      <= hold_nxt;
    rd_idx_r    <= rd_idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    f_idx_r     <= f_idx_nxt;
    f_cnt_r     <= f_cnt_nxt;
    f_free_ok_r <= f_free_ok_nxt;
    f_free_r    <= f_free_nxt;
    p_idx_r     <= p_idx_nxt;
    p_cnt_r     <= p_cnt_nxt;
    p_free_ok_r <= p_free_ok_nxt;
    p_free_r    <= p_free_nxt;
    w_idx_r     <= w_idx_nxt;
    w_pc_r      <= w_pc_nxt;
    rel_r       <= rel_nxt;
    st_r        <= st_nxt;
  end

  rwlt_result_reg u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(rb_push),
    .push_ready(rb_ready),
    .push_data (rb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (rb_out)
  );

  assign out_status         = rb_out.status;
  assign out_released_count = rb_out.released_count;

  // Checks
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("request transfer did not start work");

  a_pair_hit_needs_file: assert property (@(posedge clk) disable iff (!rst_n)
    p_hit_r |-> f_hit_r)
    else $error("pair hit recorded without its file");

  a_count_only_release_all: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && (op_r != OP_REL_ALL) |-> rel_r == '0)
    else $error("released count set for a single-lock request");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !file_we && !pair_we)
    else $error("table written while idle");

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the reader-writer lock table. Requests go in through
// the in_ channel and a scoreboard keeps its own file and holder-file tables.
// It works out the status and released count of every request and compares
// each out_ transfer against the oldest prediction. Stimulus runs in order:
// directed cases, file-table fill, pair-table fill, then random traffic under
// three idling mixes, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import rwlt_pkg::*;

  localparam int NFILE     = FILE_ENTRIES_DEF;
  localparam int NPAIR     = PAIR_ENTRIES_DEF;
  localparam int IDW       = ID_BITS_DEF;
  localparam int CNT_LIMIT = (1 << (COUNT_BITS_DEF - 1)) - 1;

  typedef struct {
    logic [ST_W-1:0]  status;
    logic [REL_W-1:0] freed;
  } lock_answer_t;

  // Lock-table predictor and result store
  class LockScoreboard;
    bit             f_live[NFILE];
    logic [IDW-1:0] f_id[NFILE];
    int             f_cnt[NFILE];
    bit             p_live[NPAIR];
    logic [IDW-1:0] p_holder[NPAIR];
    logic [IDW-1:0] p_file[NPAIR];
    int             p_cnt[NPAIR];
    lock_answer_t   pending_q[$];
    int             errors;
    int             requests;
    int             answers;
    int             status_seen[8];

    function int find_file(logic [IDW-1:0] f);
      for (int i = 0; i < NFILE; i++)
        if (f_live[i] && f_id[i] == f) return i;
      return -1;
    endfunction

    function int free_file();
      for (int i = 0; i < NFILE; i++)
        if (!f_live[i]) return i;
      return -1;
    endfunction

    function int find_pair(logic [IDW-1:0] h, logic [IDW-1:0] f);
      for (int i = 0; i < NPAIR; i++)
        if (p_live[i] && p_holder[i] == h && p_file[i] == f) return i;
      return -1;
    endfunction

    function int free_pair();
      for (int i = 0; i < NPAIR; i++)
        if (!p_live[i]) return i;
      return -1;
    endfunction

    function logic [ST_W-1:0] acquire(logic [IDW-1:0] f, logic [IDW-1:0] h, bit wr);
      int fi;
      int pi;
      int ps;
      fi = find_file(f);
      if (fi < 0) begin
        fi = free_file();
        ps = free_pair();
        if (fi < 0 || ps < 0) return ST_NOROOM;
        f_live[fi] = 1; f_id[fi] = f; f_cnt[fi] = wr ? -1 : 1;
        p_live[ps] = 1; p_holder[ps] = h; p_file[ps] = f; p_cnt[ps] = wr ? -1 : 1;
        return ST_OK;
      end
      if (f_cnt[fi] < 0 || wr) return ST_CONFLICT;
      if (f_cnt[fi] >= CNT_LIMIT) return ST_NOROOM;
      pi = find_pair(h, f);
      if (pi >= 0) begin
        if (p_cnt[pi] < 0) return ST_INCONS;
        if (p_cnt[pi] >= CNT_LIMIT) return ST_NOROOM;
        p_cnt[pi]++;
      end else begin
        pi = free_pair();
        if (pi < 0) return ST_NOROOM;
        p_live[pi] = 1; p_holder[pi] = h; p_file[pi] = f; p_cnt[pi] = 1;
      end
      f_cnt[fi]++;
      return ST_OK;
    endfunction

    function logic [ST_W-1:0] drop_one(logic [IDW-1:0] f, logic [IDW-1:0] h);
      int fi;
      int pi;
      fi = find_file(f);
      pi = find_pair(h, f);
      if (fi < 0 || pi < 0) return ST_NOTFOUND;
      if ((f_cnt[fi] < 0) != (p_cnt[pi] < 0) || (p_cnt[pi] > 0 && f_cnt[fi] < p_cnt[pi]))
        return ST_INCONS;
      if (f_cnt[fi] > 1) f_cnt[fi]--; else f_live[fi] = 0;
      if (p_cnt[pi] > 1) p_cnt[pi]--; else p_live[pi] = 0;
      return ST_OK;
    endfunction

    function logic [ST_W-1:0] drop_holder(logic [IDW-1:0] h, output int freed);
      int fi;
      freed = 0;
      for (int i = 0; i < NPAIR; i++) begin
        if (!p_live[i] || p_holder[i] != h) continue;
        fi = find_file(p_file[i]);
        if (fi < 0) return ST_INCONS;
        if (p_cnt[i] > 0 && f_cnt[fi] >= p_cnt[i]) begin
          f_cnt[fi] -= p_cnt[i];
          freed += p_cnt[i];
          if (f_cnt[fi] == 0) f_live[fi] = 0;
        end else if (p_cnt[i] < 0 && f_cnt[fi] < 0) begin
          f_live[fi] = 0;
          freed += 1;
        end else begin
          return ST_INCONS;
        end
        p_live[i] = 0;
      end
      return ST_OK;
    endfunction

    // Note an accepted request and queue its predicted answer
    function void note_request(logic [OP_W-1:0] op, logic [IDW-1:0] f, logic [IDW-1:0] h);
      lock_answer_t a;
      int n;
      n = 0;
      requests++;
      if (op == OP_REL_ALL) begin
        if (h == 0) a.status = ST_INVALID;
        else a.status = drop_holder(h, n);
      end else if (f == 0 || h == 0) begin
        a.status = ST_INVALID;
      end else if (op == OP_REL_ONE) begin
        a.status = drop_one(f, h);
      end else begin
        a.status = acquire(f, h, op == OP_ACQ_WR);
      end
      a.freed = n[REL_W-1:0];
      pending_q.push_back(a);
    endfunction

    // Check one result transfer against the oldest prediction
    function void check_result(logic [ST_W-1:0] st, logic [REL_W-1:0] rel);
      lock_answer_t a;
      answers++;
      status_seen[st]++;
      if (pending_q.size() == 0) begin
        $error("result with nothing pending: status=%0d released_count=%0d", st, rel);
        errors++;
        return;
      end
      a = pending_q.pop_front();
      if (st !== a.status) begin
        $error("status: expected %0d, actual %0d", a.status, st);
        errors++;
      end
      if (rel !== a.freed) begin
        $error("released_count: expected %0d, actual %0d", a.freed, rel);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [OP_W-1:0]  in_opcode;
  logic [IDW-1:0]   in_file_id;
  logic [IDW-1:0]   in_holder_id;
  logic             out_valid;
  logic             out_ready;
  logic [ST_W-1:0]  out_status;
  logic [REL_W-1:0] out_released_count;

  LockScoreboard sb;
  int  snd_idle_pct;
  int  rcv_idle_pct;
  bit  hold_req;
  int  hold_left;
  int  stalled_offers;

  logic [IDW-1:0] file_pool[12];
  logic [IDW-1:0] holder_pool[6];

  reader_writer_lock_table u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_file_id         (in_file_id),
    .in_holder_id       (in_holder_id),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_released_count (out_released_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_request(in_opcode, in_file_id, in_holder_id);
    if (rst_n && in_valid && !in_ready) stalled_offers++;
    if (rst_n && out_valid && out_ready) sb.check_result(out_status, out_released_count);
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = 1500;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Offer one request and hold it until the transfer
  task automatic send_req(logic [OP_W-1:0] op, logic [IDW-1:0] f, logic [IDW-1:0] h);
    bit taken;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_opcode    = op;
    in_file_id   = f;
    in_holder_id = h;
    taken        = 0;
    while (!taken) begin
      #1 taken = in_ready;
      @(negedge clk);
    end
  endtask

  task automatic rand_req();
    int pick;
    logic [IDW-1:0] f;
    logic [IDW-1:0] h;
    pick = $urandom_range(99);
    f = file_pool[$urandom_range(11)];
    h = holder_pool[$urandom_range(5)];
    if (pick < 35) send_req(OP_ACQ_RD, f, h);
    else if (pick < 52) send_req(OP_ACQ_WR, f, h);
    else if (pick < 82) send_req(OP_REL_ONE, f, h);
    else if (pick < 92) send_req(OP_REL_ALL, IDW'($urandom), h);
    else if (pick < 96) send_req(OP_W'($urandom_range(3)), IDW'($urandom), IDW'($urandom));
    else send_req(OP_W'($urandom_range(3)), ($urandom_range(1) ? f : '0),
                  ($urandom_range(1) ? h : '0));
  endtask

  initial begin
    int wait_cnt;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_ACQ_RD;
    in_file_id = '0;
    in_holder_id = '0;
    out_ready = 1'b0;
    snd_idle_pct = 28;
    rcv_idle_pct = 75;
    hold_req = 0;
    hold_left = 0;
    stalled_offers = 0;
    file_pool = '{16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA,
                  16'h0002, 16'h0003, 16'h1234, 16'hFEDC, 16'h0100, 16'h00FF};
    holder_pool = '{16'hFFFF, 16'h0001, 16'hAAAA, 16'h5555, 16'h0042, 16'h8001};
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero ids, sharing, conflicts, missing locks, release all
    send_req(OP_ACQ_RD, 16'h0000, 16'h0001);
    send_req(OP_ACQ_WR, 16'h0001, 16'h0000);
    send_req(OP_REL_ONE, 16'h0000, 16'h0000);
    send_req(OP_REL_ALL, 16'hFFFF, 16'h0000);
    send_req(OP_REL_ALL, 16'h0000, 16'h0007);
    send_req(OP_REL_ONE, 16'h0010, 16'h0001);
    send_req(OP_ACQ_RD, 16'hFFFF, 16'hFFFF);
    send_req(OP_ACQ_RD, 16'hFFFF, 16'hFFFF);
    send_req(OP_ACQ_RD, 16'hFFFF, 16'h0001);
    send_req(OP_ACQ_WR, 16'hFFFF, 16'h0002);
    send_req(OP_ACQ_WR, 16'h0001, 16'h0002);
    send_req(OP_ACQ_RD, 16'h0001, 16'h0003);
    send_req(OP_ACQ_WR, 16'h0001, 16'h0002);
    send_req(OP_REL_ONE, 16'h0001, 16'h0003);
    send_req(OP_REL_ONE, 16'hFFFF, 16'h0002);
    send_req(OP_REL_ONE, 16'hFFFF, 16'h0001);
    send_req(OP_REL_ALL, 16'h0000, 16'hFFFF);
    send_req(OP_REL_ALL, 16'h1234, 16'h0002);
    send_req(OP_REL_ALL, 16'h0000, 16'h0002);
    send_req(OP_ACQ_WR, 16'h0001, 16'h0002);
    send_req(OP_REL_ONE, 16'h0001, 16'h0002);

    // Fill the file table past its end with distinct files, then clear it
    hold_req = 1;
    for (int i = 0; i < 80; i++)
      send_req(OP_W'($urandom_range(1)), IDW'(16'h2000 + i), holder_pool[i % 6]);
    foreach (holder_pool[i]) send_req(OP_REL_ALL, IDW'($urandom), holder_pool[i]);

    // Fill the pair table past its end over a few shared files, then clear it
    for (int i = 1; i <= 140; i++) send_req(OP_ACQ_RD, IDW'(16'h3000 + (i % 3)), IDW'(i));
    for (int i = 1; i <= 140; i++) send_req(OP_REL_ALL, IDW'($urandom), IDW'(i));

    // Random traffic under three idling mixes
    for (int m = 0; m < 3; m++) begin
      snd_idle_pct = (m == 0) ? 28 : (m == 1) ? 75 : 0;
      rcv_idle_pct = (m == 0) ? 75 : (m == 1) ? 28 : 0;
      for (int i = 0; i < 360; i++) rand_req();
    end
    in_valid = 1'b0;

    // Drain outstanding results, then let the block settle
    wait_cnt = 0;
    while (sb.pending_q.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (600) @(posedge clk);
    if (sb.pending_q.size() != 0) begin
      $error("%0d results never arrived", sb.pending_q.size());
      sb.errors++;
    end
    $display("Covered %0d requests and %0d results (%0d stalled offer cycles).",
             sb.requests, sb.answers, stalled_offers);
    $display("Status mix: ok %0d, conflict %0d, invalid %0d, not found %0d, no room %0d.",
             sb.status_seen[ST_OK], sb.status_seen[ST_CONFLICT], sb.status_seen[ST_INVALID],
             sb.status_seen[ST_NOTFOUND], sb.status_seen[ST_NOROOM]);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #40000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
